[src/pfre_pkg.sv]
package pfre_pkg;

   localparam int MAX_FRAMES = 64;
   localparam int PAGE_SHIFT = 12;
   localparam int FW         = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1;
   localparam int NW         = $clog2(MAX_FRAMES + 1);
   localparam int PAGE_W     = 20;
   localparam int TIME_W     = 32;

   localparam logic [1:0] POLICY_FIFO = 2'd0;
   localparam logic [1:0] POLICY_LRU  = 2'd1;

   localparam logic [31:0] CNT_MAX = 32'hFFFF_FFFF;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_APPLY,
      ST_DONE
   } state_type;

   // word that walks down the row of frame cells
   typedef struct packed {
      logic              tvalid;
      logic              apply;
      logic [PAGE_W-1:0] page;
      logic              wr;
      logic [NW-1:0]     n;
      logic [FW-1:0]     hand;
      logic [TIME_W-1:0] now;
      logic              found;
      logic              hit;
      logic [FW-1:0]     idx;
      logic [TIME_W-1:0] min_e;
      logic [FW-1:0]     min_e_idx;
      logic [TIME_W-1:0] min_l;
      logic [FW-1:0]     min_l_idx;
      logic              have_ge;
      logic [FW-1:0]     ge_idx;
      logic              have_lt;
      logic [FW-1:0]     lt_idx;
      logic              op_hit;
      logic              clr_en;
      logic              clr_all;
      logic              wrap;
      logic              vdirty;
      logic [PAGE_W-1:0] vpage;
   } token_type;

   function automatic logic [31:0] sat_inc(input logic [31:0] v);
      return (v == CNT_MAX) ? v : v + 32'd1;
   endfunction

endpackage

[src/pfre_req_if.sv]
interface pfre_req_if;
   logic        valid;
   logic        ready;
   logic [31:0] address;
   logic        is_write;

   modport source (output valid, address, is_write, input ready);
   modport sink (input valid, address, is_write, output ready);
endinterface

[src/pfre_rsp_if.sv]
interface pfre_rsp_if;
   logic        valid;
   logic        ready;
   logic        hit;
   logic        filled_empty;
   logic        evicted;
   logic        evicted_dirty;
   logic [19:0] evicted_page;
   logic [5:0]  frame_index;
   logic [31:0] access_total;
   logic [31:0] miss_total;
   logic [31:0] writeback_total;
   logic [31:0] drop_total;

   modport source (output valid, hit, filled_empty, evicted, evicted_dirty, evicted_page,
                   frame_index, access_total, miss_total, writeback_total, drop_total,
                   input ready);
   modport sink (input valid, hit, filled_empty, evicted, evicted_dirty, evicted_page,
                 frame_index, access_total, miss_total, writeback_total, drop_total,
                 output ready);
endinterface

[src/pfre_cell.sv]
module pfre_cell
   import pfre_pkg::*;
#(
   parameter int INDEX = 0
) (
   input  logic      clock,
   input  logic      reset,
   input  token_type tok_in,
   output token_type tok_out
);

   localparam logic [NW-1:0] IDX_N = NW'(INDEX);
   localparam logic [FW-1:0] IDX_F = FW'(INDEX);

   logic              valid_ff, valid_in;
   logic              dirty_ff, dirty_in;
   logic              use_ff, use_in;
   logic [PAGE_W-1:0] page_ff, page_in;
   logic [TIME_W-1:0] entry_ff, entry_in;
   logic [TIME_W-1:0] last_ff, last_in;
   token_type         tok_ff, tok_nx;

   logic active;
   logic clr_hit;

   assign active = tok_in.tvalid && (IDX_N < tok_in.n);

   // clock sweep clears use bits between hand and victim
   assign clr_hit = tok_in.clr_all ||
                    (!tok_in.wrap && IDX_F >= tok_in.hand && IDX_F < tok_in.idx) ||
                    (tok_in.wrap && (IDX_F >= tok_in.hand || IDX_F < tok_in.idx));

   always_comb begin
      tok_nx   = tok_in;
      valid_in = valid_ff;
      dirty_in = dirty_ff;
      use_in   = use_ff;
      page_in  = page_ff;
      entry_in = entry_ff;
      last_in  = last_ff;
      if (active && !tok_in.apply) begin
         // search pass: match, empty slot, oldest stamps, free use bits
         if (!tok_in.found) begin
            if (!valid_ff) begin
               tok_nx.found = 1'b1;
               tok_nx.idx   = IDX_F;
            end else if (page_ff == tok_in.page) begin
               tok_nx.found = 1'b1;
               tok_nx.hit   = 1'b1;
               tok_nx.idx   = IDX_F;
            end
         end
         if (INDEX == 0 || entry_ff < tok_in.min_e) begin
            tok_nx.min_e     = entry_ff;
            tok_nx.min_e_idx = IDX_F;
         end
         if (INDEX == 0 || last_ff < tok_in.min_l) begin
            tok_nx.min_l     = last_ff;
            tok_nx.min_l_idx = IDX_F;
         end
         if (!use_ff) begin
            if (IDX_F >= tok_in.hand && !tok_in.have_ge) begin
               tok_nx.have_ge = 1'b1;
               tok_nx.ge_idx  = IDX_F;
            end
            if (IDX_F < tok_in.hand && !tok_in.have_lt) begin
               tok_nx.have_lt = 1'b1;
               tok_nx.lt_idx  = IDX_F;
            end
         end
      end else if (active && tok_in.apply) begin
         // update pass: write the chosen frame, sweep use bits
         if (IDX_F == tok_in.idx) begin
            if (!tok_in.found) begin
               tok_nx.vdirty = dirty_ff;
               tok_nx.vpage  = page_ff;
            end
            if (tok_in.op_hit) begin
               use_in  = 1'b1;
               last_in = tok_in.now;
               if (tok_in.wr) begin
                  dirty_in = 1'b1;
               end
            end else begin
               valid_in = 1'b1;
               page_in  = tok_in.page;
               entry_in = tok_in.now;
               last_in  = tok_in.now;
               use_in   = 1'b1;
               dirty_in = tok_in.wr;
            end
         end else if (tok_in.clr_en && clr_hit) begin
            use_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         dirty_ff <= 1'b0;
         use_ff   <= 1'b0;
         tok_ff   <= '0;
      end else begin
         valid_ff <= valid_in;
         dirty_ff <= dirty_in;
         use_ff   <= use_in;
         tok_ff   <= tok_nx;
      end
   end

   always_ff @(posedge clock) begin
      page_ff  <= page_in;
      entry_ff <= entry_in;
      last_ff  <= last_in;
   end

   assign tok_out = tok_ff;

endmodule

[src/page_frame_replacement_engine.sv]
// Fully associative page-frame table built as a row of MAX_FRAMES frame cells.
// One access word is taken at a time. A search word walks the row one cell per
// clock to find a hit or the lowest empty frame and to collect FIFO, LRU and
// clock victim candidates; a second word walks the row to write the chosen
// frame and sweep clock use bits. The result of a word is ready once both
// words have passed through the cell row. The result waits in an output
// register; the next word is accepted once the result is loaded there.
// The counters saturate at all ones. Registers: policy at 0x0,
// frames_in_use at 0x4.
module page_frame_replacement_engine
   import pfre_pkg::*;
#(
   parameter int PAGE_SHIFT_P = PAGE_SHIFT
) (
   input  logic        clock,
   input  logic        reset,
   pfre_req_if.sink    req_ch,
   pfre_rsp_if.source  rsp_ch,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [2:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);

   state_type     state_ff, state_in;
   logic [1:0]    policy_ff, policy_in;
   logic [6:0]    frames_ff, frames_in;
   logic [FW-1:0] hand_ff, hand_in;
   logic [31:0]   acc_ff, acc_in;
   logic [31:0]   acct_ff, acct_in;
   logic [31:0]   miss_ff, miss_in;
   logic [31:0]   wb_ff, wb_in;
   logic [31:0]   drop_ff, drop_in;
   token_type     launch_ff, launch_in;
   token_type     res_ff, res_in;
   logic          rsp_valid_ff, rsp_valid_in;
   logic          hit_ff, hit_in;
   logic          fill_ff, fill_in;
   logic          ev_ff, ev_in;
   logic          evd_ff, evd_in;
   logic [19:0]   evp_ff, evp_in;
   logic [5:0]    fidx_ff, fidx_in;

   token_type     tok [MAX_FRAMES+1];
   token_type     ret;
   token_type     t;
   logic [NW-1:0] n_eff;
   logic [FW-1:0] h_eff;
   logic [FW-1:0] victim;
   logic [FW:0]   victim_nx;
   logic          wr_en;

   // row of frame cells
   assign tok[0] = launch_ff;
   for (genvar g = 0; g < MAX_FRAMES; g++) begin : g_cell
      pfre_cell #(.INDEX(g)) u_cell (
         .clock   (clock),
         .reset   (reset),
         .tok_in  (tok[g]),
         .tok_out (tok[g+1])
      );
   end
   assign ret = tok[MAX_FRAMES];

   // register port
   assign csr_pready = 1'b1;
   assign wr_en      = csr_psel && csr_penable && csr_pwrite;
   assign csr_prdata = csr_paddr[2] ? {25'd0, frames_ff} : {30'd0, policy_ff};

   // clamp frame count and hand
   always_comb begin
      if (frames_ff == 7'd0) begin
         n_eff = NW'(1);
      end else if ({25'd0, frames_ff} > 32'(MAX_FRAMES)) begin
         n_eff = NW'(MAX_FRAMES);
      end else begin
         n_eff = NW'(frames_ff);
      end
      h_eff = (NW'(hand_ff) < n_eff) ? hand_ff : '0;
   end

   always_comb begin
      state_in     = state_ff;
      policy_in    = policy_ff;
      frames_in    = frames_ff;
      hand_in      = hand_ff;
      acc_in       = acc_ff;
      acct_in      = acct_ff;
      miss_in      = miss_ff;
      wb_in        = wb_ff;
      drop_in      = drop_ff;
      launch_in    = '0;
      res_in       = res_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ch.ready;
      hit_in       = hit_ff;
      fill_in      = fill_ff;
      ev_in        = ev_ff;
      evd_in       = evd_ff;
      evp_in       = evp_ff;
      fidx_in      = fidx_ff;
      t            = ret;
      victim       = '0;
      victim_nx    = '0;
      req_ch.ready = (state_ff == ST_IDLE);

      if (wr_en) begin
         if (csr_paddr[2]) begin
            frames_in = csr_pwdata[6:0];
         end else begin
            policy_in = csr_pwdata[1:0];
         end
      end

      unique case (state_ff)
         ST_IDLE: begin
            // launch search word
            if (req_ch.valid) begin
               acc_in           = sat_inc(acc_ff);
               launch_in.tvalid = 1'b1;
               launch_in.page   = PAGE_W'(req_ch.address >> PAGE_SHIFT_P);
               launch_in.wr     = req_ch.is_write;
               launch_in.n      = n_eff;
               launch_in.hand   = h_eff;
               launch_in.now    = sat_inc(acc_ff);
               state_in         = ST_SCAN;
            end
         end
         ST_SCAN: begin
            // pick the frame, launch update word
            if (ret.tvalid) begin
               t.apply = 1'b1;
               if (ret.hit) begin
                  t.op_hit = 1'b1;
               end else if (!ret.found) begin
                  if (policy_ff == POLICY_FIFO) begin
                     victim = ret.min_e_idx;
                  end else if (policy_ff == POLICY_LRU) begin
                     victim = ret.min_l_idx;
                  end else begin
                     t.clr_en = 1'b1;
                     if (ret.have_ge) begin
                        victim = ret.ge_idx;
                     end else if (ret.have_lt) begin
                        victim = ret.lt_idx;
                        t.wrap = 1'b1;
                     end else begin
                        victim    = ret.hand;
                        t.clr_all = 1'b1;
                     end
                     victim_nx = {1'b0, victim} + 1'b1;
                     hand_in   = (NW'(victim_nx) == ret.n) ? '0 : victim_nx[FW-1:0];
                  end
                  t.idx = victim;
               end
               launch_in = t;
               state_in  = ST_APPLY;
            end
         end
         ST_APPLY: begin
            if (ret.tvalid) begin
               res_in   = ret;
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            // load result once the output register is free
            if (!rsp_valid_ff || rsp_ch.ready) begin
               rsp_valid_in = 1'b1;
               hit_in       = res_ff.hit;
               fill_in      = res_ff.found && !res_ff.hit;
               ev_in        = !res_ff.found;
               evd_in       = !res_ff.found && res_ff.vdirty;
               evp_in       = res_ff.found ? 20'd0 : res_ff.vpage;
               fidx_in      = 6'(res_ff.idx);
               acct_in      = acc_ff;
               if (!res_ff.found) begin
                  miss_in = sat_inc(miss_ff);
                  if (res_ff.vdirty) begin
                     wb_in = sat_inc(wb_ff);
                  end else begin
                     drop_in = sat_inc(drop_ff);
                  end
               end
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         policy_ff    <= 2'd0;
         frames_ff    <= 7'd64;
         hand_ff      <= '0;
         acc_ff       <= '0;
         miss_ff      <= '0;
         wb_ff        <= '0;
         drop_ff      <= '0;
         launch_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         policy_ff    <= policy_in;
         frames_ff    <= frames_in;
         hand_ff      <= hand_in;
         acc_ff       <= acc_in;
         miss_ff      <= miss_in;
         wb_ff        <= wb_in;
         drop_ff      <= drop_in;
         launch_ff    <= launch_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      res_ff  <= res_in;
      hit_ff  <= hit_in;
      fill_ff <= fill_in;
      ev_ff   <= ev_in;
      evd_ff  <= evd_in;
      evp_ff  <= evp_in;
      fidx_ff <= fidx_in;
      acct_ff <= acct_in;
   end

   // result channel
   assign rsp_ch.valid           = rsp_valid_ff;
   assign rsp_ch.hit             = hit_ff;
   assign rsp_ch.filled_empty    = fill_ff;
   assign rsp_ch.evicted         = ev_ff;
   assign rsp_ch.evicted_dirty   = evd_ff;
   assign rsp_ch.evicted_page    = evp_ff;
   assign rsp_ch.frame_index     = fidx_ff;
   assign rsp_ch.access_total    = acct_ff;
   assign rsp_ch.miss_total      = miss_ff;
   assign rsp_ch.writeback_total = wb_ff;
   assign rsp_ch.drop_total      = drop_ff;

endmodule

[dv/pfre_tb_checker.sv]
`timescale 1ns / 100ps

module pfre_tb_checker
   import pfre_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   pfre_req_if         req,
   pfre_rsp_if         rsp,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic        csr_pready,
   input  logic [2:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output int          mismatch_count,
   output int          pending_count
);

   localparam logic [2:0] ADDR_POLICY = 3'h0;
   localparam logic [2:0] ADDR_FRAMES = 3'h4;

   typedef struct packed {
      bit        hit;
      bit        filled_empty;
      bit        evicted;
      bit        evicted_dirty;
      bit [19:0] evicted_page;
      bit [5:0]  frame_index;
      bit [31:0] access_total;
      bit [31:0] miss_total;
      bit [31:0] writeback_total;
      bit [31:0] drop_total;
   } outcome_t;

   // shadow of the block's table and registers
   bit [1:0]        pol_q;
   bit [6:0]        frames_q;
   bit [19:0]       page_q  [MAX_FRAMES];
   bit              valid_q [MAX_FRAMES];
   bit              dirty_q [MAX_FRAMES];
   bit              use_q   [MAX_FRAMES];
   bit [31:0]       entry_q [MAX_FRAMES];
   bit [31:0]       last_q  [MAX_FRAMES];
   int              hand_q;
   bit [31:0]       acc_q, miss_q, wb_q, drop_q;

   outcome_t        outcome_fifo[$];

   function automatic bit [31:0] bump(input bit [31:0] v);
      return (v == 32'hFFFF_FFFF) ? v : v + 32'd1;
   endfunction

   // compute the outcome of one access and update the shadow table
   task automatic predict_access(input bit [31:0] addr, input bit wr, output outcome_t o);
      int        n;
      int        i;
      int        steps;
      int        h;
      int        victim;
      bit [31:0] now;
      bit [19:0] pg;
      bit        found;
      o = '0;
      n = (frames_q == 0) ? 1 : ((frames_q > MAX_FRAMES) ? MAX_FRAMES : frames_q);
      pg = addr[31:12];
      acc_q = bump(acc_q);
      now = acc_q;
      found = 0;
      for (i = 0; i < n && !found; i++) begin
         if (!valid_q[i]) begin
            o.filled_empty = 1;
            o.frame_index = 6'(i);
            found = 1;
         end else if (page_q[i] == pg) begin
            o.hit = 1;
            o.frame_index = 6'(i);
            found = 1;
         end
      end
      if (o.hit) begin
         use_q[o.frame_index] = 1;
         last_q[o.frame_index] = now;
         if (wr) dirty_q[o.frame_index] = 1;
      end else begin
         if (!o.filled_empty) begin
            miss_q = bump(miss_q);
            victim = 0;
            if (pol_q == POLICY_FIFO) begin
               for (i = 1; i < n; i++) if (entry_q[i] < entry_q[victim]) victim = i;
            end else if (pol_q == POLICY_LRU) begin
               for (i = 1; i < n; i++) if (last_q[i] < last_q[victim]) victim = i;
            end else begin
               // second chance: sweep use bits from the hand
               h = (hand_q < n) ? hand_q : 0;
               victim = h;
               for (steps = 0; steps < n; steps++) begin
                  if (!use_q[h]) begin
                     victim = h;
                     break;
                  end
                  use_q[h] = 0;
                  h = (h + 1) % n;
               end
               hand_q = (victim + 1) % n;
            end
            o.frame_index = 6'(victim);
            o.evicted = 1;
            o.evicted_dirty = dirty_q[victim];
            o.evicted_page = page_q[victim];
            if (dirty_q[victim]) wb_q = bump(wb_q);
            else drop_q = bump(drop_q);
         end
         valid_q[o.frame_index] = 1;
         page_q[o.frame_index] = pg;
         entry_q[o.frame_index] = now;
         last_q[o.frame_index] = now;
         use_q[o.frame_index] = 1;
         dirty_q[o.frame_index] = wr;
      end
      o.access_total = acc_q;
      o.miss_total = miss_q;
      o.writeback_total = wb_q;
      o.drop_total = drop_q;
   endtask

   task automatic check_field(input string name, input bit [31:0] exp_v, input bit [31:0] act_v);
      if (exp_v !== act_v) begin
         mismatch_count++;
         $display("%0t: %s expected 0x%0h actual 0x%0h", $time, name, exp_v, act_v);
      end
   endtask

   initial mismatch_count = 0;
   assign pending_count = outcome_fifo.size();

   always @(posedge clock) begin
      outcome_t o;
      if (reset) begin
         pol_q = POLICY_FIFO;
         frames_q = 7'd64;
         for (int i = 0; i < MAX_FRAMES; i++) begin
            page_q[i] = 0; valid_q[i] = 0; dirty_q[i] = 0;
            use_q[i] = 0; entry_q[i] = 0; last_q[i] = 0;
         end
         hand_q = 0;
         acc_q = 0; miss_q = 0; wb_q = 0; drop_q = 0;
         outcome_fifo.delete();
      end else begin
         // follow register writes
         if (csr_psel && csr_penable && csr_pwrite && csr_pready) begin
            if (csr_paddr == ADDR_POLICY) pol_q = csr_pwdata[1:0];
            else if (csr_paddr == ADDR_FRAMES) frames_q = csr_pwdata[6:0];
         end
         // compare the delivered word with the oldest outcome
         if (rsp.valid && rsp.ready) begin
            if (outcome_fifo.size() == 0) begin
               mismatch_count++;
               $display("%0t: result word with none expected, actual hit=%0b idx=%0d",
                        $time, rsp.hit, rsp.frame_index);
            end else begin
               o = outcome_fifo.pop_front();
               check_field("hit", o.hit, rsp.hit);
               check_field("filled_empty", o.filled_empty, rsp.filled_empty);
               check_field("evicted", o.evicted, rsp.evicted);
               check_field("evicted_dirty", o.evicted_dirty, rsp.evicted_dirty);
               check_field("evicted_page", o.evicted_page, rsp.evicted_page);
               check_field("frame_index", o.frame_index, rsp.frame_index);
               check_field("access_total", o.access_total, rsp.access_total);
               check_field("miss_total", o.miss_total, rsp.miss_total);
               check_field("writeback_total", o.writeback_total, rsp.writeback_total);
               check_field("drop_total", o.drop_total, rsp.drop_total);
            end
         end
         // predict each accepted access word
         if (req.valid && req.ready) begin
            predict_access(req.address, req.is_write, o);
            outcome_fifo.push_back(o);
         end
      end
   end

endmodule

[dv/page_frame_replacement_engine_tb.sv]
`timescale 1ns / 100ps

module page_frame_replacement_engine_tb;
   import pfre_pkg::*;

   localparam logic [2:0] ADDR_POLICY = 3'h0;
   localparam logic [2:0] ADDR_FRAMES = 3'h4;
   localparam logic [1:0] POL_CLOCK   = 2'd2;
   localparam logic [1:0] POL_ALT     = 2'd3;
   localparam int         TAIL_CYCLES = 2 * MAX_FRAMES + 20;

   logic        clock = 0;
   logic        reset = 1;
   logic        csr_psel = 0, csr_penable = 0, csr_pwrite = 0;
   logic [2:0]  csr_paddr = 0;
   logic [31:0] csr_pwdata = 0;
   logic [31:0] csr_prdata;
   logic        csr_pready;
   int          mismatch_count, pending_count;
   int          sent_words = 0, rcvd_words = 0;
   bit          hold_long = 0, no_idle = 0;
   bit [19:0]   page_pool[80];

   pfre_req_if req_ch();
   pfre_rsp_if rsp_ch();

   initial begin
      req_ch.valid = 0;
      req_ch.address = 0;
      req_ch.is_write = 0;
      rsp_ch.ready = 0;
   end

   page_frame_replacement_engine u_top (
      .clock(clock), .reset(reset), .req_ch(req_ch), .rsp_ch(rsp_ch),
      .csr_psel(csr_psel), .csr_penable(csr_penable), .csr_pwrite(csr_pwrite),
      .csr_paddr(csr_paddr), .csr_pwdata(csr_pwdata), .csr_prdata(csr_prdata),
      .csr_pready(csr_pready)
   );

   pfre_tb_checker u_checker (
      .clock(clock), .reset(reset), .req(req_ch), .rsp(rsp_ch),
      .csr_psel(csr_psel), .csr_penable(csr_penable), .csr_pwrite(csr_pwrite),
      .csr_pready(csr_pready), .csr_paddr(csr_paddr), .csr_pwdata(csr_pwdata),
      .mismatch_count(mismatch_count), .pending_count(pending_count)
   );

   always begin
      #2 clock = 1;
      #2 clock = 0;
   end

   initial begin
      #5ms;
      $display("Mismatches found");
      $finish;
   end

   always @(posedge clock) if (!reset && rsp_ch.valid && rsp_ch.ready) rcvd_words++;

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 19);
      if (no_idle || r < 12) return 0;
      if (r < 18) return $urandom_range(1, 3);
      return $urandom_range(10, 60);
   endfunction

   // result side: random back-pressure, one long hold-off on request
   initial begin
      int k;
      @(negedge reset);
      forever begin
         if (hold_long) begin
            rsp_ch.ready <= 0;
            for (k = 0; k < 800; k++) @(posedge clock);
            hold_long = 0;
         end else begin
            k = pick_gap();
            if (k == 0) begin
               rsp_ch.ready <= 1;
               repeat ($urandom_range(1, 8)) @(posedge clock);
            end else begin
               rsp_ch.ready <= 0;
               repeat (k) @(posedge clock);
            end
         end
      end
   end

   task automatic send_word(input logic [31:0] addr, input logic wr);
      int gap;
      req_ch.valid <= 1;
      req_ch.address <= addr;
      req_ch.is_write <= wr;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      sent_words++;
      gap = pick_gap();
      if (gap > 0) begin
         req_ch.valid <= 0;
         repeat (gap) @(posedge clock);
      end
   endtask

   // setup cycle then access cycle
   task automatic csr_write(input logic [2:0] addr, input logic [31:0] data);
      req_ch.valid <= 0;
      while (rcvd_words != sent_words) @(posedge clock);
      csr_psel <= 1; csr_penable <= 0; csr_pwrite <= 1;
      csr_paddr <= addr; csr_pwdata <= data;
      @(posedge clock);
      csr_penable <= 1;
      @(posedge clock);
      csr_psel <= 0; csr_penable <= 0; csr_pwrite <= 0;
      @(posedge clock);
   endtask

   task automatic set_mode(input logic [1:0] pol, input logic [6:0] frames);
      csr_write(ADDR_POLICY, {$urandom} & 32'hFFFF_FFFC | {30'd0, pol});
      csr_write(ADDR_FRAMES, {$urandom} & 32'hFFFF_FF80 | {25'd0, frames});
   endtask

   // mostly accesses to a small set of pages, some fully random
   task automatic random_phase(input int count, input int pool_size);
      logic [31:0] addr;
      for (int i = 0; i < 80; i++) page_pool[i] = 20'($urandom);
      for (int i = 0; i < count; i++) begin
         addr = $urandom;
         if ($urandom_range(0, 7) != 0)
            addr[31:12] = page_pool[$urandom_range(0, pool_size - 1)];
         send_word(addr, 1'($urandom_range(0, 1)));
      end
   endtask

   initial begin
      repeat (3) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // defaults: FIFO over 64 frames, address extremes, hit turning dirty
      send_word(32'h0000_0000, 0);
      send_word(32'hFFFF_FFFF, 1);
      send_word(32'h0000_0FFF, 1);
      send_word(32'hFFFF_F000, 0);
      // zero frames acts as one: every new page evicts, dirty then clean
      set_mode(POLICY_LRU, 7'd0);
      send_word(32'h1234_5678, 1);
      send_word(32'hABCD_E000, 0);
      send_word(32'h5555_5555, 0);
      // clock over eight frames, all use bits set on the first eviction
      set_mode(POL_CLOCK, 7'd8);
      for (int i = 1; i <= 9; i++) send_word(i << 12, i[0]);
      send_word(32'h0000_3000, 0);
      send_word(32'h0000_A000, 0);
      // shrink under a hand past the end, then the unused policy code
      set_mode(POL_CLOCK, 7'd2);
      send_word(32'h0000_B000, 1);
      set_mode(POL_ALT, 7'd3);
      send_word(32'h0000_C000, 0);
      send_word(32'h0000_D000, 0);
      // count above the table size acts as full size
      set_mode(POLICY_FIFO, 7'd127);
      send_word(32'h7FFF_F123, 1);

      set_mode(POLICY_FIFO, 7'd64);
      random_phase(110, 72);
      set_mode(POLICY_LRU, 7'd64);
      hold_long = 1;
      random_phase(110, 72);
      set_mode(POL_CLOCK, 7'd64);
      random_phase(110, 72);
      set_mode(POLICY_LRU, 7'd1);
      random_phase(80, 3);
      set_mode(POL_CLOCK, 7'd1);
      random_phase(80, 3);
      set_mode(POLICY_FIFO, 7'd8);
      no_idle = 1;
      random_phase(110, 12);
      no_idle = 0;
      set_mode(POL_ALT, 7'd16);
      random_phase(110, 22);
      set_mode(POL_CLOCK, 7'd5);
      random_phase(110, 8);
      set_mode(POLICY_LRU, 7'd40);
      random_phase(110, 48);
      set_mode(POLICY_FIFO, 7'd127);
      random_phase(110, 72);

      req_ch.valid <= 0;
      while (rcvd_words != sent_words) @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);
      if (mismatch_count == 0 && pending_count == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule

[filelist.f]
src/pfre_pkg.sv
src/pfre_req_if.sv
src/pfre_rsp_if.sv
src/pfre_cell.sv
src/page_frame_replacement_engine.sv
dv/pfre_tb_checker.sv
dv/page_frame_replacement_engine_tb.sv
